// ===== rtl/joint_move_sequencer_assert.svh =====
// Assertion macros used by the joint move sequencer checker.
`ifndef JOINT_MOVE_SEQUENCER_ASSERT_SVH
`define JOINT_MOVE_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define JMS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define JMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jms_pkg.sv =====
// Shared types, constants and helper functions of the joint move sequencer.
package jms_pkg;

   localparam int ANGLE_STEPS = 360;
   localparam int ANGLE_W     = 9;
   localparam int COUNT_W     = 9;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;

   localparam logic [ANGLE_W-1:0] ANGLE_ZERO = '0;
   localparam logic [ANGLE_W-1:0] ANGLE_LAST = ANGLE_W'(ANGLE_STEPS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   typedef enum logic [1:0] {
      PH_FETCH  = 2'd0,
      PH_PUT    = 2'd1,
      PH_RETURN = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      JOINT_BASE  = 2'd0,
      JOINT_LOWER = 2'd1,
      JOINT_UPPER = 2'd2,
      JOINT_NONE  = 2'd3
   } joint_type;

   typedef enum logic [2:0] {
      REG_FETCH_BASE  = 3'd0,
      REG_FETCH_LOWER = 3'd1,
      REG_FETCH_UPPER = 3'd2,
      REG_PUT_BASE    = 3'd3,
      REG_PUT_LOWER   = 3'd4,
      REG_PUT_UPPER   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic        [8:0] fetch_base_steps;
      logic signed [8:0] fetch_lower_steps;
      logic        [7:0] fetch_upper_steps;
      logic signed [9:0] put_base_steps;
      logic signed [9:0] put_lower_steps;
      logic signed [9:0] put_upper_steps;
   } cfg_type;

   typedef struct packed {
      phase_type                    phase;
      logic [2:0][ANGLE_W-1:0]      angle;
      logic [2:0][COUNT_W-1:0]      fetch_count;
      logic [2:0][COUNT_W-1:0]      put_count;
   } state_type;

   typedef struct packed {
      logic      step_up;
      joint_type moved_joint;
   } move_type;

   // Magnitude of a 10 bit signed count, clipped to what a step counter holds.
   function automatic logic [COUNT_W-1:0] step_mag(input logic [9:0] v);
      logic [9:0] a;
      a = v[9] ? (~v + 10'd1) : v;
      return (a > {1'b0, COUNT_MAX}) ? COUNT_MAX : a[COUNT_W-1:0];
   endfunction

   // One degree up or down with wrap.
   function automatic logic [ANGLE_W-1:0] rotate(input logic [ANGLE_W-1:0] a,
                                                 input logic up);
      logic [ANGLE_W-1:0] r;
      if (up) begin
         r = (a >= ANGLE_LAST) ? ANGLE_ZERO : a + ANGLE_W'(1);
      end else begin
         r = (a == ANGLE_ZERO) ? ANGLE_LAST : a - ANGLE_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/joint_move_sequencer.sv =====
// Top level of the joint move sequencer: request register, state, result register.
//
//   channel  | direction | word
//   req_     | in        | tdata[0] advance
//   rsp_     | out       | tdata angles, phase, moved joint, step direction
//   csr_     | in/out    | six step-count registers at byte address 4*index
//
// One word per cycle sustained while the result side accepts; each word passes
// through the request register and then lands in the result register.
// The joint state updates as a word moves into the result register.
// Reset is synchronous and clears the state, the step-count registers and both valids.
// A stalled result holds; a new request is still taken while the request
// register is empty or is moving forward.
module joint_move_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [jms_pkg::REQ_DATA_W-1:0] req_tdata,   // [0] advance, [7:1] zero
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [jms_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [8:0] base_angle,
                                                       // [17:9] lower_angle,
                                                       // [26:18] upper_angle,
                                                       // [28:27] phase,
                                                       // [30:29] moved_joint,
                                                       // [31] step_up
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [jms_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [jms_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [jms_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import jms_pkg::*;

   cfg_type                cfg;
   state_type              state_ff;
   state_type              state_in;
   move_type               move_in;
   logic                   in_vld_ff;
   logic                   adv_ff;
   logic                   out_vld_ff;
   logic [RSP_DATA_W-1:0]  out_data_ff;
   logic [RSP_DATA_W-1:0]  out_data_in;
   logic                   fire;

   jms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jms_step u_step (
      .cfg     (cfg),
      .cur     (state_ff),
      .advance (adv_ff),
      .nxt     (state_in),
      .move    (move_in)
   );

   // handshake: the request register moves when the result slot frees up
   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   assign out_data_in = {move_in.step_up, move_in.moved_joint, state_in.phase,
                         state_in.angle[2], state_in.angle[1], state_in.angle[0]};

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         adv_ff <= req_tdata[0];
      end
   end

   // motion state, all zero is the fetch phase at home
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (fire) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ===== rtl/jms_csr.sv =====
// Configuration register file with an APB-style write/read port.
module jms_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [jms_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [jms_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [jms_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output jms_pkg::cfg_type              cfg
);
   import jms_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_FETCH_BASE:  cfg_in.fetch_base_steps  = csr_pwdata[8:0];
            REG_FETCH_LOWER: cfg_in.fetch_lower_steps = csr_pwdata[8:0];
            REG_FETCH_UPPER: cfg_in.fetch_upper_steps = csr_pwdata[7:0];
            REG_PUT_BASE:    cfg_in.put_base_steps    = csr_pwdata[9:0];
            REG_PUT_LOWER:   cfg_in.put_lower_steps   = csr_pwdata[9:0];
            REG_PUT_UPPER:   cfg_in.put_upper_steps   = csr_pwdata[9:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux, raw register bits zero-extended
   always_comb begin
      case (idx)
         REG_FETCH_BASE:  csr_prdata = {23'd0, cfg_ff.fetch_base_steps};
         REG_FETCH_LOWER: csr_prdata = {23'd0, cfg_ff.fetch_lower_steps};
         REG_FETCH_UPPER: csr_prdata = {24'd0, cfg_ff.fetch_upper_steps};
         REG_PUT_BASE:    csr_prdata = {22'd0, cfg_ff.put_base_steps};
         REG_PUT_LOWER:   csr_prdata = {22'd0, cfg_ff.put_lower_steps};
         REG_PUT_UPPER:   csr_prdata = {22'd0, cfg_ff.put_upper_steps};
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/jms_step.sv =====
// Next-state logic for one motion tick: picks the joint, direction and phase.
module jms_step (
   input  jms_pkg::cfg_type   cfg,
   input  jms_pkg::state_type cur,
   input  logic               advance,
   output jms_pkg::state_type nxt,
   output jms_pkg::move_type  move
);
   import jms_pkg::*;

   logic [COUNT_W-1:0] fetch_lower_mag;
   logic [COUNT_W-1:0] put_base_mag;
   logic [COUNT_W-1:0] put_lower_mag;
   logic [COUNT_W-1:0] put_upper_mag;
   joint_type          moved;
   logic               up;

   assign fetch_lower_mag = step_mag({cfg.fetch_lower_steps[8], cfg.fetch_lower_steps});
   assign put_base_mag    = step_mag(cfg.put_base_steps);
   assign put_lower_mag   = step_mag(cfg.put_lower_steps);
   assign put_upper_mag   = step_mag(cfg.put_upper_steps);

   // joint selection and counters, by phase
   always_comb begin
      nxt   = cur;
      moved = JOINT_NONE;
      up    = 1'b0;
      if (advance) begin
         case (cur.phase)
            PH_FETCH: begin
               if (cur.fetch_count[0] < cfg.fetch_base_steps) begin
                  moved = JOINT_BASE;
                  up    = 1'b1;
                  nxt.fetch_count[0] = cur.fetch_count[0] + COUNT_W'(1);
               end else if (cur.fetch_count[1] < fetch_lower_mag) begin
                  moved = JOINT_LOWER;
                  up    = cfg.fetch_lower_steps[8];
                  nxt.fetch_count[1] = cur.fetch_count[1] + COUNT_W'(1);
               end else if (cur.fetch_count[2] < {1'b0, cfg.fetch_upper_steps}) begin
                  moved = JOINT_UPPER;
                  up    = 1'b0;
                  nxt.fetch_count[2] = cur.fetch_count[2] + COUNT_W'(1);
               end else begin
                  nxt.phase = PH_PUT;
               end
            end
            PH_PUT: begin
               if (cur.put_count[0] < put_base_mag) begin
                  moved = JOINT_BASE;
                  up    = !cfg.put_base_steps[9];
                  nxt.put_count[0] = cur.put_count[0] + COUNT_W'(1);
               end else if (cur.put_count[1] < put_lower_mag) begin
                  moved = JOINT_LOWER;
                  up    = cfg.put_lower_steps[9];
                  nxt.put_count[1] = cur.put_count[1] + COUNT_W'(1);
               end else if (cur.put_count[2] < put_upper_mag) begin
                  moved = JOINT_UPPER;
                  up    = cfg.put_upper_steps[9];
                  nxt.put_count[2] = cur.put_count[2] + COUNT_W'(1);
               end else begin
                  nxt.phase = PH_RETURN;
               end
            end
            PH_RETURN: begin
               // step up toward zero through the wrap
               up = 1'b1;
               if (cur.angle[0] != ANGLE_ZERO) begin
                  moved = JOINT_BASE;
               end else if (cur.angle[1] != ANGLE_ZERO) begin
                  moved = JOINT_LOWER;
               end else if (cur.angle[2] != ANGLE_ZERO) begin
                  moved = JOINT_UPPER;
               end else begin
                  up        = 1'b0;
                  nxt.phase = PH_DONE;
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end

      // apply the single-degree move
      case (moved)
         JOINT_BASE:  nxt.angle[0] = rotate(cur.angle[0], up);
         JOINT_LOWER: nxt.angle[1] = rotate(cur.angle[1], up);
         JOINT_UPPER: nxt.angle[2] = rotate(cur.angle[2], up);
         default:     nxt.angle    = cur.angle;
      endcase
   end

   assign move.moved_joint = moved;
   assign move.step_up     = (moved != JOINT_NONE) && up;

endmodule

// ===== rtl/jms_checker.sv =====
// Port-level checker for the joint move sequencer, bound to the top level.
`include "joint_move_sequencer_assert.svh"

module jms_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [jms_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import jms_pkg::*;

   logic [ANGLE_W-1:0] base_a;
   logic [ANGLE_W-1:0] lower_a;
   logic [ANGLE_W-1:0] upper_a;
   phase_type          ph;
   joint_type          mj;
   logic               su;

   assign base_a  = rsp_tdata[8:0];
   assign lower_a = rsp_tdata[17:9];
   assign upper_a = rsp_tdata[26:18];
   assign ph      = phase_type'(rsp_tdata[28:27]);
   assign mj      = joint_type'(rsp_tdata[30:29]);
   assign su      = rsp_tdata[31];

   // stalled result word holds
   `JMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")

   // angles stay inside one turn
   `JMS_ASSERT_IMPLY(a_angle_range, clock, reset, rsp_tvalid, (base_a <= ANGLE_LAST) && (lower_a <= ANGLE_LAST) && (upper_a <= ANGLE_LAST), "joint angle out of range")

   // no direction without a move
   `JMS_ASSERT_IMPLY(a_idle_dir, clock, reset, rsp_tvalid && (mj == JOINT_NONE), !su, "step_up set with no joint moved")

   // done phase never moves a joint, and leaves every joint at zero
   `JMS_ASSERT_IMPLY(a_done_still, clock, reset, rsp_tvalid && (ph == PH_DONE), (mj == JOINT_NONE) && (base_a == ANGLE_ZERO) && (lower_a == ANGLE_ZERO) && (upper_a == ANGLE_ZERO), "motion in done phase")

   // return phase only steps upward
   `JMS_ASSERT_IMPLY(a_return_up, clock, reset, rsp_tvalid && (ph == PH_RETURN) && (mj != JOINT_NONE), su, "return step went down")

endmodule

bind joint_move_sequencer jms_checker u_jms_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the joint move sequencer: scripted rows, random epochs, then the return home.
module testbench;
   import jms_pkg::*;

   localparam int ITEMS_PER_EPOCH = 60;
   localparam int EPOCHS          = 8;
   localparam int TAIL_ITEMS      = 16;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_CYCLES     = 48;
   localparam int COUNTER_TOP     = 511;

   // result word, lowest field in the lowest bits
   typedef struct packed {
      logic               step_up;
      joint_type          moved_joint;
      phase_type          phase;
      logic [ANGLE_W-1:0] upper_angle;
      logic [ANGLE_W-1:0] lower_angle;
      logic [ANGLE_W-1:0] base_angle;
   } arm_pose_type;

   // one scripted row: a register write or an input word
   typedef struct packed {
      logic          is_reg;
      reg_index_type idx;
      logic [9:0]    value;
      logic          advance;
      logic          known;
      arm_pose_type  pose;
   } script_row_type;

   localparam script_row_type SCRIPT [0:16] = '{
      // after reset: reports the home pose
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b0, 1'b1,
        '{1'b0, JOINT_NONE, PH_FETCH, 9'd0, 9'd0, 9'd0}},
      '{1'b1, REG_FETCH_BASE,  10'd1, 1'b0, 1'b0, '0},
      '{1'b1, REG_FETCH_LOWER, 10'd1, 1'b0, 1'b0, '0},
      '{1'b1, REG_FETCH_UPPER, 10'd1, 1'b0, 1'b0, '0},
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b1, 1'b1,
        '{1'b1, JOINT_BASE, PH_FETCH, 9'd0, 9'd0, 9'd1}},
      // lower joint wraps down below zero
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b1, 1'b1,
        '{1'b0, JOINT_LOWER, PH_FETCH, 9'd0, 9'd359, 9'd1}},
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b1, 1'b1,
        '{1'b0, JOINT_UPPER, PH_FETCH, 9'd359, 9'd359, 9'd1}},
      // idle word: no motion
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b0, 1'b1,
        '{1'b0, JOINT_NONE, PH_FETCH, 9'd359, 9'd359, 9'd1}},
      // raise targets mid-run, lower joint now steps up
      '{1'b1, REG_FETCH_BASE,  10'd3,     1'b0, 1'b0, '0},
      '{1'b1, REG_FETCH_LOWER, 10'h1FD,   1'b0, 1'b0, '0},
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b1, 1'b0, '0},
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b1, 1'b0, '0},
      // lower joint wraps up through zero
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b1, 1'b1,
        '{1'b1, JOINT_LOWER, PH_FETCH, 9'd359, 9'd0, 9'd3}},
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b1, 1'b0, '0},
      '{1'b1, REG_FETCH_UPPER, 10'd2, 1'b0, 1'b0, '0},
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b1, 1'b0, '0},
      '{1'b0, REG_FETCH_BASE, 10'd0, 1'b0, 1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the arm state and step targets
   phase_type          arm_phase = PH_FETCH;
   logic [ANGLE_W-1:0] arm_angle [3] = '{default: '0};
   int                 fetch_cnt [3] = '{default: 0};
   int                 put_cnt [3]   = '{default: 0};
   int                 step_target [6] = '{default: 0};

   arm_pose_type expected_poses [$];
   int           fault_count    = 0;
   logic         reset_released = 1'b0;
   logic         source_steady  = 1'b0;
   logic         sink_steady    = 1'b0;
   int           sink_hold      = 0;

   joint_move_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // register value as the block sees it: masked, signed where the field is
   function automatic int field_value(input reg_index_type idx, input logic [31:0] raw);
      case (idx)
         REG_FETCH_BASE:  return int'(raw[8:0]);
         REG_FETCH_LOWER: return int'($signed(raw[8:0]));
         REG_FETCH_UPPER: return int'(raw[7:0]);
         default:         return int'($signed(raw[9:0]));
      endcase
   endfunction

   // step count reachable by a signed target
   function automatic int clip_mag(input int v);
      int a;
      a = (v < 0) ? -v : v;
      return (a > COUNTER_TOP) ? COUNTER_TOP : a;
   endfunction

   function automatic logic [ANGLE_W-1:0] turn_joint(input logic [ANGLE_W-1:0] a,
                                                     input logic up);
      if (up) begin
         return (a == ANGLE_W'(ANGLE_STEPS - 1)) ? '0 : a + 1'b1;
      end
      return (a == '0) ? ANGLE_W'(ANGLE_STEPS - 1) : a - 1'b1;
   endfunction

   // one motion tick of the arm; returns the pose that the block reports
   function automatic arm_pose_type predict_tick(input logic advance);
      joint_type    moved;
      logic         up;
      int           lo, pb, pl, pu;
      arm_pose_type pose;
      moved = JOINT_NONE;
      up    = 1'b0;
      if (advance) begin
         case (arm_phase)
            PH_FETCH: begin
               lo = step_target[REG_FETCH_LOWER];
               if (fetch_cnt[0] < step_target[REG_FETCH_BASE]) begin
                  moved = JOINT_BASE;
                  up    = 1'b1;
                  fetch_cnt[0]++;
               end else if (fetch_cnt[1] < clip_mag(lo)) begin
                  moved = JOINT_LOWER;
                  up    = (lo < 0);
                  fetch_cnt[1]++;
               end else if (fetch_cnt[2] < step_target[REG_FETCH_UPPER]) begin
                  moved = JOINT_UPPER;
                  fetch_cnt[2]++;
               end else begin
                  arm_phase = PH_PUT;
               end
            end
            PH_PUT: begin
               pb = step_target[REG_PUT_BASE];
               pl = step_target[REG_PUT_LOWER];
               pu = step_target[REG_PUT_UPPER];
               if (put_cnt[0] < clip_mag(pb)) begin
                  moved = JOINT_BASE;
                  up    = (pb >= 0);
                  put_cnt[0]++;
               end else if (put_cnt[1] < clip_mag(pl)) begin
                  moved = JOINT_LOWER;
                  up    = (pl < 0);
                  put_cnt[1]++;
               end else if (put_cnt[2] < clip_mag(pu)) begin
                  moved = JOINT_UPPER;
                  up    = (pu < 0);
                  put_cnt[2]++;
               end else begin
                  arm_phase = PH_RETURN;
               end
            end
            PH_RETURN: begin
               if (arm_angle[0] != '0) moved = JOINT_BASE;
               else if (arm_angle[1] != '0) moved = JOINT_LOWER;
               else if (arm_angle[2] != '0) moved = JOINT_UPPER;
               else arm_phase = PH_DONE;
               up = (moved != JOINT_NONE);
            end
            default: ;
         endcase
         if (moved != JOINT_NONE) arm_angle[moved] = turn_joint(arm_angle[moved], up);
      end
      pose.base_angle  = arm_angle[0];
      pose.lower_angle = arm_angle[1];
      pose.upper_angle = arm_angle[2];
      pose.phase       = arm_phase;
      pose.moved_joint = moved;
      pose.step_up     = (moved != JOINT_NONE) && up;
      return pose;
   endfunction

   function automatic string pose_text(input arm_pose_type p);
      return $sformatf("base %0d lower %0d upper %0d phase %0d joint %0d up %0d",
                       p.base_angle, p.lower_angle, p.upper_angle, p.phase,
                       p.moved_joint, p.step_up);
   endfunction

   // compare one result word with the oldest expected pose
   task automatic check_pose(input arm_pose_type got);
      arm_pose_type want;
      if (expected_poses.size() == 0) begin
         fault_count++;
         if (fault_count <= 10) $display("unexpected result word: %s", pose_text(got));
      end else begin
         want = expected_poses.pop_front();
         if (got.base_angle != want.base_angle || got.lower_angle != want.lower_angle ||
             got.upper_angle != want.upper_angle || got.phase != want.phase ||
             got.moved_joint != want.moved_joint || got.step_up != want.step_up) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("mismatch: expected %s", pose_text(want));
               $display("          actual   %s", pose_text(got));
            end
         end
      end
   endtask

   // offer one input word, predict its result once taken
   task automatic send_word(input logic advance, input logic known, input arm_pose_type pose);
      int gap;
      gap = source_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(advance);
      do @(posedge clock); while (req_tready !== 1'b1);
      if (known) begin
         void'(predict_tick(advance));
         expected_poses.push_back(pose);
      end else begin
         expected_poses.push_back(predict_tick(advance));
      end
   endtask

   // stop offering and let every pending result drain
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // setup phase, access phase, then the bus returns to idle
   task automatic write_step_reg(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      step_target[idx] = field_value(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // targets per epoch: fetch epochs first, then put epochs with fetch cleared
   function automatic logic [31:0] epoch_setting(input int e, input reg_index_type idx);
      logic [31:0] v;
      v = $urandom();
      if (idx <= REG_FETCH_UPPER) begin
         if (e >= 4) v = '0;
         else if (e == 0) v = (idx == REG_FETCH_BASE)  ? 32'h1FF :
                              (idx == REG_FETCH_LOWER) ? 32'h100 : 32'hFF;
         else if (e == 1 && idx == REG_FETCH_LOWER) v = 32'h0FF;
      end else begin
         if (e == 4) v = 32'h200;
         else if (e == 5) v = 32'h1FF;
      end
      return v;
   endfunction

   // result side: random stalls, one long hold on request
   initial begin : result_sink
      int stall;
      wait (reset_released);
      forever begin
         if (sink_hold > 0) begin
            stall     = sink_hold;
            sink_hold = 0;
         end else if (sink_steady) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         check_pose(arm_pose_type'(rsp_tdata));
      end
   end

   // ends the run when no word moves for too long
   initial begin : stall_watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      script_row_type row;
      int             tail;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset          <= 1'b0;
      reset_released  = 1'b1;

      // scripted fetch moves
      foreach (SCRIPT[i]) begin
         row = SCRIPT[i];
         if (row.is_reg) begin
            quiesce();
            write_step_reg(row.idx, {22'd0, row.value});
         end else begin
            send_word(row.advance, row.known, row.pose);
         end
      end

      // random epochs, fresh targets at each start
      for (int e = 0; e < EPOCHS; e++) begin
         quiesce();
         for (int r = 0; r < 6; r++) write_step_reg(reg_index_type'(r),
                                                    epoch_setting(e, reg_index_type'(r)));
         source_steady = ($urandom_range(0, 3) == 0);
         sink_steady   = ($urandom_range(0, 3) == 0);
         if (e == 2) begin
            sink_hold     = HOLD_CYCLES;
            source_steady = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_EPOCH; n++)
            send_word($urandom_range(0, 3) != 0, 1'b0, '0);
      end

      // clear all targets, ride the return home and a few ticks past done
      quiesce();
      for (int r = 0; r < 6; r++) write_step_reg(reg_index_type'(r), '0);
      source_steady = 1'b0;
      sink_steady   = 1'b0;
      tail          = 0;
      while (tail < TAIL_ITEMS) begin
         send_word(1'b1, 1'b0, '0);
         if (arm_phase == PH_DONE) tail++;
      end
      quiesce();

      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== joint_move_sequencer.f =====
+incdir+rtl
rtl/jms_pkg.sv
rtl/jms_csr.sv
rtl/jms_step.sv
rtl/joint_move_sequencer.sv
rtl/jms_checker.sv
dv/testbench.sv
